### rtl/core/mef_pkg.sv
// Shared constants, control word type and microcode ROM of the edge fragmenter.
package mef_pkg;

  localparam int COORD_W   = 32;
  localparam int STEP_W    = 16;
  localparam int MAX_FRAGS = 31;
  localparam int K_W       = $clog2(MAX_FRAGS + 2);
  localparam int EXT_W     = COORD_W + 1;
  localparam int PC_W      = 4;
  localparam int COND_W    = 3;

  // jump conditions
  localparam logic [COND_W-1:0] COND_NEVER     = 3'd0;
  localparam logic [COND_W-1:0] COND_ALWAYS    = 3'd1;
  localparam logic [COND_W-1:0] COND_NO_BEAT   = 3'd2;
  localparam logic [COND_W-1:0] COND_NO_PREV   = 3'd3;
  localparam logic [COND_W-1:0] COND_OUT_BUSY  = 3'd4;
  localparam logic [COND_W-1:0] COND_FRAG_MORE = 3'd5;
  localparam logic [COND_W-1:0] COND_NOT_LAST  = 3'd6;

  // program addresses
  localparam logic [PC_W-1:0] PC_WAIT    = 4'd0;
  localparam logic [PC_W-1:0] PC_CHECK   = 4'd1;
  localparam logic [PC_W-1:0] PC_LOAD_A  = 4'd2;
  localparam logic [PC_W-1:0] PC_START_A = 4'd3;
  localparam logic [PC_W-1:0] PC_FRAG_A  = 4'd4;
  localparam logic [PC_W-1:0] PC_UPDATE  = 4'd5;
  localparam logic [PC_W-1:0] PC_LOAD_B  = 4'd6;
  localparam logic [PC_W-1:0] PC_START_B = 4'd7;
  localparam logic [PC_W-1:0] PC_FRAG_B  = 4'd8;
  localparam logic [PC_W-1:0] PC_DONE    = 4'd9;

  typedef struct packed {
    logic              in_ready;
    logic              load_a;
    logic              load_b;
    logic              upd_prev;
    logic              emit_start;
    logic              emit_frag;
    logic              edge_b;
    logic [COND_W-1:0] cond;
    logic [PC_W-1:0]   target;
  } ucode_t;

  function automatic ucode_t ucode_rom(input logic [PC_W-1:0] pc);
    ucode_t w;
    w = '0;
    w.cond = COND_NEVER;
    w.target = PC_WAIT;
    case (pc)
      PC_WAIT: begin
        w.in_ready = 1'b1;
        w.cond = COND_NO_BEAT;
        w.target = PC_WAIT;
      end
      PC_CHECK: begin
        w.cond = COND_NO_PREV;
        w.target = PC_UPDATE;
      end
      PC_LOAD_A: begin
        w.load_a = 1'b1;
      end
      PC_START_A: begin
        w.emit_start = 1'b1;
        w.cond = COND_OUT_BUSY;
        w.target = PC_START_A;
      end
      PC_FRAG_A: begin
        w.emit_frag = 1'b1;
        w.cond = COND_FRAG_MORE;
        w.target = PC_FRAG_A;
      end
      PC_UPDATE: begin
        w.upd_prev = 1'b1;
        w.cond = COND_NOT_LAST;
        w.target = PC_DONE;
      end
      PC_LOAD_B: begin
        w.load_b = 1'b1;
        w.edge_b = 1'b1;
      end
      PC_START_B: begin
        w.emit_start = 1'b1;
        w.edge_b = 1'b1;
        w.cond = COND_OUT_BUSY;
        w.target = PC_START_B;
      end
      PC_FRAG_B: begin
        w.emit_frag = 1'b1;
        w.edge_b = 1'b1;
        w.cond = COND_FRAG_MORE;
        w.target = PC_FRAG_B;
      end
      PC_DONE: begin
        w.cond = COND_ALWAYS;
        w.target = PC_WAIT;
      end
      default: begin
        w.cond = COND_ALWAYS;
        w.target = PC_WAIT;
      end
    endcase
    return w;
  endfunction

endpackage

### rtl/core/mef_if.sv
// Valid/ready channel interfaces for vertex beats and point beats.
interface mef_vertex_if import mef_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] vertex_x;
  logic signed [COORD_W-1:0] vertex_y;
  logic                      last_vertex;

  modport source (output valid, output vertex_x, output vertex_y, output last_vertex,
                  input ready);
  modport sink (input valid, input vertex_x, input vertex_y, input last_vertex,
                output ready);
endinterface

interface mef_point_if import mef_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] point_x;
  logic signed [COORD_W-1:0] point_y;
  logic                      run_end;
  logic                      poly_close;
  logic                      truncated;

  modport source (output valid, output point_x, output point_y, output run_end,
                  output poly_close, output truncated, input ready);
  modport sink (input valid, input point_x, input point_y, input run_end,
                input poly_close, input truncated, output ready);
endinterface

### rtl/core/manhattan_edge_fragmenter.sv
// Top level: microcoded edge fragmenter for Manhattan polygon outlines.
//
//   channel   dir  handshake          payload
//   vertex    in   valid/ready        vertex_x, vertex_y, last_vertex
//   point     out  valid/ready        point_x, point_y, run_end, poly_close, truncated
//   cfg       in   cfg_we             cfg_wdata = step_size
//
// One vertex at a time: a 10-step microprogram runs per vertex, and while an edge is emitted one point
// leaves per cycle unless point stalls; a vertex emits up to 64 points.
// The step counter and the single output register set that pace.
// rst is synchronous: step counter, open-polygon flag, step_size (to 1) and out valid clear.
// A stall on point holds the sequencer in its emit step; vertex is taken only in the wait step.
module manhattan_edge_fragmenter import mef_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [STEP_W-1:0] cfg_wdata,
  mef_vertex_if.sink        vertex,
  mef_point_if.source       point
);

  logic [PC_W-1:0]   pc, pc_next;
  ucode_t            uc;
  logic              cond_true;

  logic [STEP_W-1:0] step_size;
  logic [STEP_W-1:0] step_eff;
  logic              have_vertex;

  logic signed [COORD_W-1:0] cur_x, cur_y, first_x, first_y, prev_x, prev_y;
  logic                      last_r;

  // edge datapath
  logic signed [COORD_W-1:0] ax_r, ay_r;
  logic signed [EXT_W-1:0]   lo_r, hi_r, c_r;
  logic [K_W-1:0]            k_r;
  logic                      vert_r, diag_r, trunc_r;

  logic signed [COORD_W-1:0] sel_ax, sel_ay, sel_bx, sel_by;
  logic                      sel_vert, sel_diag;
  logic signed [EXT_W-1:0]   sel_lo, sel_hi, c_next;
  logic [EXT_W-1:0]          span, frag_lim;
  logic                      trunc_calc;
  logic                      pending;

  logic out_valid, out_free, in_fire, start_fire, frag_fire, edge_final, run_end_calc;
  logic signed [COORD_W-1:0] out_x, out_y;
  logic out_run_end, out_poly_end, out_trunc;

  assign uc       = ucode_rom(pc);
  assign step_eff = (step_size == '0) ? STEP_W'(1) : step_size;
  assign out_free = !out_valid || point.ready;
  assign in_fire  = vertex.valid && uc.in_ready && !rst;

  always_comb begin
    case (uc.cond)
      COND_NEVER:     cond_true = 1'b0;
      COND_ALWAYS:    cond_true = 1'b1;
      COND_NO_BEAT:   cond_true = !vertex.valid;
      COND_NO_PREV:   cond_true = !have_vertex;
      COND_OUT_BUSY:  cond_true = !out_free;
      COND_FRAG_MORE: cond_true = pending;
      COND_NOT_LAST:  cond_true = !last_r;
      default:        cond_true = 1'b1;
    endcase
    pc_next = cond_true ? uc.target : pc + PC_W'(1);
  end

  // edge set-up: open edge runs prev->cur, closing edge runs cur->first
  always_comb begin
    sel_ax = uc.load_b ? cur_x : prev_x;
    sel_ay = uc.load_b ? cur_y : prev_y;
    sel_bx = uc.load_b ? first_x : cur_x;
    sel_by = uc.load_b ? first_y : cur_y;
    sel_vert = (sel_ax == sel_bx);
    sel_diag = !sel_vert && (sel_ay != sel_by);
    if (sel_vert) begin
      sel_lo = (sel_ay < sel_by) ? EXT_W'(sel_ay) : EXT_W'(sel_by);
      sel_hi = (sel_ay < sel_by) ? EXT_W'(sel_by) : EXT_W'(sel_ay);
    end else begin
      sel_lo = (sel_ax < sel_bx) ? EXT_W'(sel_ax) : EXT_W'(sel_bx);
      sel_hi = (sel_ax < sel_bx) ? EXT_W'(sel_bx) : EXT_W'(sel_ax);
    end
  end

  assign c_next     = c_r + $signed({{(EXT_W - STEP_W){1'b0}}, step_eff});
  assign span       = $unsigned(hi_r - lo_r);
  assign frag_lim   = EXT_W'(step_eff) * EXT_W'(MAX_FRAGS + 1);
  // more than the limit fits when span - 1 >= (limit + 1) * step
  assign trunc_calc = !diag_r && (span > frag_lim);
  assign pending    = !diag_r && (c_r < hi_r) && (k_r <= K_W'(MAX_FRAGS));

  assign start_fire = uc.emit_start && out_free;
  assign frag_fire  = uc.emit_frag && pending && out_free;

  always_comb begin
    if (uc.emit_start) begin
      edge_final = diag_r || !(c_r < hi_r);
    end else begin
      edge_final = !(c_next < hi_r) || (k_r == K_W'(MAX_FRAGS));
    end
    run_end_calc = edge_final && (uc.edge_b || !last_r);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc          <= PC_WAIT;
      have_vertex <= 1'b0;
      step_size   <= STEP_W'(1);
      out_valid   <= 1'b0;
    end else begin
      pc <= pc_next;
      if (cfg_we) begin
        step_size <= cfg_wdata;
      end
      if (uc.upd_prev) begin
        have_vertex <= !last_r;
      end
      if (start_fire || frag_fire) begin
        out_valid <= 1'b1;
      end else if (point.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      cur_x  <= vertex.vertex_x;
      cur_y  <= vertex.vertex_y;
      last_r <= vertex.last_vertex;
      if (!have_vertex) begin
        first_x <= vertex.vertex_x;
        first_y <= vertex.vertex_y;
      end
    end
    if (uc.upd_prev) begin
      prev_x <= cur_x;
      prev_y <= cur_y;
    end
    if (uc.load_a || uc.load_b) begin
      ax_r   <= sel_ax;
      ay_r   <= sel_ay;
      lo_r   <= sel_lo;
      hi_r   <= sel_hi;
      c_r    <= sel_lo + $signed({{(EXT_W - STEP_W){1'b0}}, step_eff});
      k_r    <= K_W'(1);
      vert_r <= sel_vert;
      diag_r <= sel_diag;
    end
    if (start_fire) begin
      trunc_r      <= trunc_calc;
      out_x        <= ax_r;
      out_y        <= ay_r;
      out_trunc    <= trunc_calc;
      out_run_end  <= run_end_calc;
      out_poly_end <= run_end_calc && last_r;
    end
    if (frag_fire) begin
      // advance to the next fragment point
      c_r          <= c_next;
      k_r          <= k_r + K_W'(1);
      out_x        <= vert_r ? ax_r : c_r[COORD_W-1:0];
      out_y        <= vert_r ? c_r[COORD_W-1:0] : ay_r;
      out_trunc    <= trunc_r;
      out_run_end  <= run_end_calc;
      out_poly_end <= run_end_calc && last_r;
    end
  end

  assign vertex.ready     = uc.in_ready && !rst;
  assign point.valid      = out_valid;
  assign point.point_x    = out_x;
  assign point.point_y    = out_y;
  assign point.run_end    = out_run_end;
  assign point.poly_close = out_poly_end;
  assign point.truncated  = out_trunc;

`ifndef SYNTHESIS
  a_frag_count: assert property (@(posedge clk) disable iff (rst)
    frag_fire |-> (k_r <= K_W'(MAX_FRAGS)))
    else $error("fragment count past limit");

  a_poly_end_run_end: assert property (@(posedge clk) disable iff (rst)
    (point.valid && point.poly_close) |-> point.run_end)
    else $error("polygon end without run end");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (point.valid && !point.ready) |=> ($stable(point.point_x) && $stable(point.point_y)))
    else $error("stalled point overwritten");

  a_closing_last: assert property (@(posedge clk) disable iff (rst)
    uc.load_b |-> last_r)
    else $error("closing edge without last vertex");
`endif

endmodule
